// ----- hdl/ultrasonic_echo_ranger_top_assert.svh -----
// Assertion macros for the echo ranger. Each check is clocked on clk and
// released while rst is high.
`ifndef ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define UER_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UER_ASSERT_SAME(lbl, ante, cons, msg)
`define UER_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/uer_pkg.sv -----
package uer_pkg;

  // Measurement phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SETTLE  = 3'd1,
    PH_TRIGGER = 3'd2,
    PH_LISTEN  = 3'd3,
    PH_PULSE   = 3'd4
  } phase_t;

  // Status codes of a finished measurement
  localparam logic [1:0] ST_MEASURED = 2'd0;
  localparam logic [1:0] ST_NO_ECHO  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LISTEN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 8'd3;

  // Reset values of the configuration registers
  localparam logic [15:0] SETTLE_RST  = 16'd2000;
  localparam logic [15:0] TRIGGER_RST = 16'd10000;
  localparam logic [15:0] LISTEN_RST  = 16'd30000;
  localparam logic [11:0] SCALE_RST   = 12'd1124;

  localparam int unsigned DIST_W = 20;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic [15:0] settle_ticks;
    logic [15:0] trigger_ticks;
    logic [15:0] listen_limit;
    logic [11:0] scale_q16;
  } cfg_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        status;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage

// ----- hdl/uer_cfg.sv -----
module uer_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output uer_pkg::cfg_t                 cfg
);
  import uer_pkg::*;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks  <= SETTLE_RST;
      cfg.trigger_ticks <= TRIGGER_RST;
      cfg.listen_limit  <= LISTEN_RST;
      cfg.scale_q16     <= SCALE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SETTLE:  cfg.settle_ticks  <= cfg_data;
        REG_TRIGGER: cfg.trigger_ticks <= cfg_data;
        REG_LISTEN:  cfg.listen_limit  <= cfg_data;
        REG_SCALE:   cfg.scale_q16     <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/uer_core.sv -----
module uer_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          start_request,
  input  logic          echo_level,
  input  uer_pkg::cfg_t cfg,
  output uer_pkg::res_t res
);
  import uer_pkg::*;

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned CMP_W = (CW > 16) ? CW : 16;
  localparam int unsigned PW    = CW + 12;
  localparam int unsigned SW    = (CW + 4 > DIST_W) ? CW + 4 : DIST_W + 1;

  phase_t            phase, phase_next, ent_phase;
  logic [CW-1:0]     phase_count, phase_count_next, ent_pc;
  logic [CW-1:0]     listen_count, listen_count_next, ent_lc;
  logic [CW-1:0]     pulse_count, pulse_count_next;
  logic [DIST_W-1:0] last_distance, last_distance_next;
  logic [1:0]        last_status, last_status_next;
  logic              trig, done;
  logic [PW-1:0]     prod;
  logic [SW-1:0]     scaled;
  logic [DIST_W-1:0] dist_calc;

  // A saturated counter counts as having reached any limit
  function automatic logic reached(input logic [CW-1:0] cnt, input logic [15:0] lim);
    reached = (CMP_W'(cnt) >= CMP_W'(lim)) || (cnt == {CW{1'b1}});
  endfunction

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] cnt);
    bump = (cnt == {CW{1'b1}}) ? cnt : cnt + CW'(1);
  endfunction

  // Pulse length to distance, saturating at the field maximum
  always_comb begin
    prod      = PW'(pulse_count) * PW'(cfg.scale_q16);
    scaled    = SW'(prod[PW-1:8]);
    dist_calc = (scaled > SW'(DIST_MAX)) ? DIST_MAX : scaled[DIST_W-1:0];
  end

  // Phase entered this tick, with zero-length phases skipped
  always_comb begin
    ent_phase = phase;
    ent_pc    = phase_count;
    ent_lc    = listen_count;
    if (ent_phase == PH_IDLE && start_request) begin
      ent_phase = PH_SETTLE;
      ent_pc    = '0;
    end
    if (ent_phase == PH_SETTLE && reached(ent_pc, cfg.settle_ticks)) begin
      ent_phase = PH_TRIGGER;
      ent_pc    = '0;
    end
    if (ent_phase == PH_TRIGGER && reached(ent_pc, cfg.trigger_ticks)) begin
      ent_phase = PH_LISTEN;
      ent_pc    = '0;
      ent_lc    = '0;
    end
  end

  // Next state
  always_comb begin
    phase_next         = ent_phase;
    phase_count_next   = ent_pc;
    listen_count_next  = ent_lc;
    pulse_count_next   = pulse_count;
    last_status_next   = last_status;
    last_distance_next = last_distance;
    case (ent_phase)
      PH_IDLE: begin
      end
      PH_SETTLE, PH_TRIGGER: begin
        phase_count_next = bump(ent_pc);
      end
      PH_LISTEN: begin
        if (reached(ent_lc, cfg.listen_limit)) begin
          phase_next         = PH_IDLE;
          last_status_next   = ST_NO_ECHO;
          last_distance_next = '0;
        end else begin
          if (echo_level) begin
            phase_next       = PH_PULSE;
            pulse_count_next = CW'(1);
          end
          listen_count_next = bump(ent_lc);
        end
      end
      PH_PULSE: begin
        if (!echo_level) begin
          phase_next         = PH_IDLE;
          last_status_next   = ST_MEASURED;
          last_distance_next = dist_calc;
        end else if (reached(ent_lc, cfg.listen_limit)) begin
          phase_next         = PH_IDLE;
          last_status_next   = ST_TOO_LONG;
          last_distance_next = '0;
        end else begin
          pulse_count_next  = bump(pulse_count);
          listen_count_next = bump(ent_lc);
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Outputs of this tick
  always_comb begin
    trig = 1'b0;
    done = 1'b0;
    case (ent_phase)
      PH_TRIGGER: trig = 1'b1;
      PH_LISTEN:  done = reached(ent_lc, cfg.listen_limit);
      PH_PULSE:   done = !echo_level || reached(ent_lc, cfg.listen_limit);
      default: begin
      end
    endcase
  end

  assign res.trigger_level = trig;
  assign res.busy_res      = (phase_next != PH_IDLE);
  assign res.done_res      = done;
  assign res.status        = last_status_next;
  assign res.distance      = last_distance_next;

  // Advance the state once per processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_count   <= '0;
      listen_count  <= '0;
      pulse_count   <= '0;
      last_status   <= ST_MEASURED;
      last_distance <= '0;
    end else if (step) begin
      phase         <= phase_next;
      phase_count   <= phase_count_next;
      listen_count  <= listen_count_next;
      pulse_count   <= pulse_count_next;
      last_status   <= last_status_next;
      last_distance <= last_distance_next;
    end
  end

endmodule

// ----- hdl/ultrasonic_echo_ranger_top.sv -----
// Ultrasonic echo ranger. Each input transfer is one microsecond tick carrying
// a start request and the sampled echo level; each tick yields exactly one
// result transfer with the trigger level, busy and done flags, and the status
// and distance (1/256 cm) of the last finished measurement. One tick is taken
// every clock cycle; a result goes through the input register, then the
// result register, and a stalled result port stalls the input only once both
// registers are full. Configuration must be written through the cfg port while
// no tick is in flight; the block does not enforce this. Writes are registered.
`include "ultrasonic_echo_ranger_top_assert.svh"

module ultrasonic_echo_ranger_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: [0] start_request, [1] echo_level, [7:2] zero
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,
  // m_tdata: [0] trigger_level, [1] busy_res, [3:2] status, [23:4] distance
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,
  // m_tlast: done_res
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import uer_pkg::*;

  cfg_t cfg;
  res_t res_comb;
  res_t res_q;
  logic in_valid;
  logic in_start;
  logic in_echo;
  logic advance;
  logic step;

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uer_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .start_request (in_start),
    .echo_level    (in_echo),
    .cfg           (cfg),
    .res           (res_comb)
  );

  // Input register: load on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_start <= s_tdata[0];
      in_echo  <= s_tdata[1];
    end
  end

  // Result register: hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_comb;
    end
  end

  assign m_tdata = {res_q.distance, res_q.status, res_q.busy_res, res_q.trigger_level};
  assign m_tlast = res_q.done_res;

  `UER_ASSERT_SAME(a_done_not_busy, m_tvalid && m_tlast, !m_tdata[1],
    "finished measurement still reported busy")
  `UER_ASSERT_SAME(a_trig_busy, m_tvalid && m_tdata[0], m_tdata[1],
    "trigger driven while idle")
  `UER_ASSERT_SAME(a_status_code, m_tvalid,
    m_tdata[3:2] == ST_MEASURED || m_tdata[3:2] == ST_NO_ECHO ||
    m_tdata[3:2] == ST_TOO_LONG, "undefined status code")
  `UER_ASSERT_SAME(a_dist_status, m_tvalid && m_tdata[23:4] != '0,
    m_tdata[3:2] == ST_MEASURED, "distance reported with error status")
  `UER_ASSERT_NEXT(a_in_hold, in_valid && !advance, in_valid,
    "pending tick dropped during output stall")

endmodule
